/* rtl/core/trsa_pkg.sv */
// Shared types and constants for the transient resource slot allocator.
// Used by the top level, the slot RAM users and the port checker; depends on nothing.
`default_nettype none

package trsa_pkg;

  // Pool sizes and pass range
  localparam int TEX_SLOTS  = 32;
  localparam int BUF_SLOTS  = 32;
  localparam int MAX_PASSES = 256;

  localparam int TEX_AW = (TEX_SLOTS > 1) ? $clog2(TEX_SLOTS) : 1;
  localparam int BUF_AW = (BUF_SLOTS > 1) ? $clog2(BUF_SLOTS) : 1;
  localparam int IDX_W  = (TEX_AW > BUF_AW) ? TEX_AW : BUF_AW;
  localparam int CNT_W  = IDX_W + 1;
  localparam int PASS_W = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

  // Operation codes
  localparam logic [2:0] OP_BEGIN_FRAME = 3'd0;
  localparam logic [2:0] OP_TEX_REQ     = 3'd1;
  localparam logic [2:0] OP_BUF_REQ     = 3'd2;
  localparam logic [2:0] OP_DROP_TEX    = 3'd3;
  localparam logic [2:0] OP_DROP_BUF    = 3'd4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [PASS_W-1:0] pass_t;
  typedef logic [4:0]        slot_num_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [4:0]  pixel_format;
    logic [14:0] tex_width;
    logic [14:0] tex_height;
    logic [3:0]  mip_count;
    logic [7:0]  usage_mask;
    logic [31:0] buffer_bytes;
    logic        host_visible;
    logic [7:0]  first_use;
    logic [7:0]  last_use;
  } req_t;

  typedef struct packed {
    slot_num_t slot_number;
    logic      fresh_slot;
    logic      pool_full;
  } rsp_t;

  typedef struct packed {
    logic [4:0]  fmt;
    logic [14:0] w;
    logic [14:0] h;
    logic [3:0]  mips;
    logic [7:0]  usage;
  } tex_desc_t;

  typedef struct packed {
    logic [31:0] bytes;
    logic        vis;
    logic [7:0]  usage;
  } buf_desc_t;

  // Saturate a pass position to the last legal pass.
  function automatic pass_t clamp_pass(input logic [7:0] v);
    if (32'(v) > MAX_PASSES - 1) begin
      return pass_t'(MAX_PASSES - 1);
    end
    return pass_t'(v);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/trsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the slot descriptors of the allocator.
`default_nettype none

module trsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* rtl/core/transient_resource_slot_allocator.sv */
// Transient resource slot allocator, top level.
// Depends on trsa_pkg and two trsa_ram instances (texture and buffer descriptors).
`default_nettype none

// Greedy interval coloring of transient textures and buffers onto two persistent
// slot pools. A request scans its pool from slot 0 and takes the first slot whose
// descriptor is compatible and whose last use lies before the request's first use;
// otherwise it appends a slot, or reports pool_full when the pool is at capacity.
// Timing: a texture or buffer request scans N slots, one per cycle through the shared
// compare unit fed by the descriptor RAM's registered read port. N is the taken slot
// plus one on reuse, the fill count on an append or a full pool, and 1 when the pool
// is empty. The result goes from the scan state through the done state into the
// output register, and the next input is taken once the block is back in idle.
// Begin-frame, drop and unused operation codes skip the scan and go straight to the
// done state. The input is stalled while an item is in flight; a finished result
// waits in the output register, so the next item can be taken while it is still
// stalled downstream. A second finished item waits in the done state for as long as
// that register stays stalled.
// No clearing pass is needed after reset: per-slot free marks are flip-flops and
// descriptors past the fill count never take part in a match.

module transient_resource_slot_allocator (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire trsa_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output trsa_pkg::rsp_t     out_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  trsa_pkg::req_t req_r, req_nxt;            // captured request
  trsa_pkg::idx_t idx_r, idx_nxt;            // scan position
  trsa_pkg::cnt_t tex_cnt_r, tex_cnt_nxt;    // slots in use per pool
  trsa_pkg::cnt_t buf_cnt_r, buf_cnt_nxt;
  logic [trsa_pkg::TEX_SLOTS-1:0] tex_vld_r, tex_vld_nxt;  // 0: free since frame start
  logic [trsa_pkg::BUF_SLOTS-1:0] buf_vld_r, buf_vld_nxt;
  trsa_pkg::pass_t tex_pass_r [trsa_pkg::TEX_SLOTS];       // last use per slot
  trsa_pkg::pass_t buf_pass_r [trsa_pkg::BUF_SLOTS];
  trsa_pkg::rsp_t res_r, res_nxt;
  logic           out_valid_r, out_valid_nxt;
  trsa_pkg::rsp_t out_data_r, out_data_nxt;

  // descriptor RAM ports
  trsa_pkg::idx_t      scan_addr;
  trsa_pkg::idx_t      wr_addr;
  logic                tex_we, buf_we;
  trsa_pkg::tex_desc_t tex_rd_data, tex_wr_data;
  trsa_pkg::buf_desc_t buf_rd_data, buf_wr_data;

  // pass table write
  logic            tex_pass_we, buf_pass_we;
  trsa_pkg::idx_t  pass_wr_idx;

  // shared compare unit
  logic            is_tex;
  trsa_pkg::pass_t first_pass, last_pass;
  logic            tex_match, buf_match, tex_free, buf_free, cur_match;
  trsa_pkg::cnt_t  cur_cnt, cur_cap, idx_ext;
  logic            in_range, hit, last_slot;

  trsa_ram #(
    .WIDTH ($bits(trsa_pkg::tex_desc_t)),
    .DEPTH (trsa_pkg::TEX_SLOTS)
  ) u_tex_ram (
    .clk     (clk),
    .wr_en   (tex_we),
    .wr_addr (wr_addr[trsa_pkg::TEX_AW-1:0]),
    .wr_data (tex_wr_data),
    .rd_addr (scan_addr[trsa_pkg::TEX_AW-1:0]),
    .rd_data (tex_rd_data)
  );

  trsa_ram #(
    .WIDTH ($bits(trsa_pkg::buf_desc_t)),
    .DEPTH (trsa_pkg::BUF_SLOTS)
  ) u_buf_ram (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (wr_addr[trsa_pkg::BUF_AW-1:0]),
    .wr_data (buf_wr_data),
    .rd_addr (scan_addr[trsa_pkg::BUF_AW-1:0]),
    .rd_data (buf_rd_data)
  );

  // Compare the slot at idx_r (its descriptor arrives from the RAM this cycle).
  always_comb begin
    is_tex     = (req_r.operation == trsa_pkg::OP_TEX_REQ);
    first_pass = trsa_pkg::clamp_pass(req_r.first_use);
    last_pass  = trsa_pkg::clamp_pass(req_r.last_use);

    tex_match = (tex_rd_data.fmt == req_r.pixel_format) &&
                (tex_rd_data.w == req_r.tex_width) &&
                (tex_rd_data.h == req_r.tex_height) &&
                (tex_rd_data.mips == req_r.mip_count) &&
                ((tex_rd_data.usage & req_r.usage_mask) == req_r.usage_mask);
    buf_match = (buf_rd_data.bytes >= req_r.buffer_bytes) &&
                (buf_rd_data.vis == req_r.host_visible) &&
                ((buf_rd_data.usage & req_r.usage_mask) == req_r.usage_mask);

    // a cleared mark stands for last use -1, free for any first use
    tex_free = !tex_vld_r[idx_r[trsa_pkg::TEX_AW-1:0]] ||
               (tex_pass_r[idx_r[trsa_pkg::TEX_AW-1:0]] < first_pass);
    buf_free = !buf_vld_r[idx_r[trsa_pkg::BUF_AW-1:0]] ||
               (buf_pass_r[idx_r[trsa_pkg::BUF_AW-1:0]] < first_pass);

    cur_match = is_tex ? (tex_match && tex_free) : (buf_match && buf_free);
    cur_cnt   = is_tex ? tex_cnt_r : buf_cnt_r;
    cur_cap   = is_tex ? trsa_pkg::cnt_t'(trsa_pkg::TEX_SLOTS)
                       : trsa_pkg::cnt_t'(trsa_pkg::BUF_SLOTS);
    idx_ext   = trsa_pkg::cnt_t'(idx_r);
    in_range  = idx_ext < cur_cnt;
    hit       = in_range && cur_match;
    last_slot = (idx_ext + trsa_pkg::cnt_t'(1)) >= cur_cnt;

    tex_wr_data = '{fmt: req_r.pixel_format, w: req_r.tex_width, h: req_r.tex_height,
                    mips: req_r.mip_count, usage: req_r.usage_mask};
    buf_wr_data = '{bytes: req_r.buffer_bytes, vis: req_r.host_visible,
                    usage: req_r.usage_mask};
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    tex_cnt_nxt   = tex_cnt_r;
    buf_cnt_nxt   = buf_cnt_r;
    tex_vld_nxt   = tex_vld_r;
    buf_vld_nxt   = buf_vld_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    scan_addr     = idx_r;
    wr_addr       = trsa_pkg::idx_t'(cur_cnt);
    tex_we        = 1'b0;
    buf_we        = 1'b0;
    tex_pass_we   = 1'b0;
    buf_pass_we   = 1'b0;
    pass_wr_idx   = idx_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        scan_addr = '0;
        if (in_valid) begin
          req_nxt = in_data;
          idx_nxt = '0;
          res_nxt = '0;
          if (in_data.operation inside {trsa_pkg::OP_TEX_REQ, trsa_pkg::OP_BUF_REQ}) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
            case (in_data.operation)
              trsa_pkg::OP_BEGIN_FRAME: begin
                tex_vld_nxt = '0;
                buf_vld_nxt = '0;
              end
              trsa_pkg::OP_DROP_TEX: begin
                tex_vld_nxt = '0;
                tex_cnt_nxt = '0;
              end
              trsa_pkg::OP_DROP_BUF: begin
                buf_vld_nxt = '0;
                buf_cnt_nxt = '0;
              end
              default: begin
                // unused codes: no state change, zero result
              end
            endcase
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          // reuse: slot now busy until this request's last use
          tex_pass_we = is_tex;
          buf_pass_we = !is_tex;
          pass_wr_idx = idx_r;
          if (is_tex) begin
            tex_vld_nxt[idx_r[trsa_pkg::TEX_AW-1:0]] = 1'b1;
          end else begin
            buf_vld_nxt[idx_r[trsa_pkg::BUF_AW-1:0]] = 1'b1;
          end
          res_nxt.slot_number = trsa_pkg::slot_num_t'(idx_r);
          state_nxt           = ST_DONE;
        end else if (last_slot) begin
          if (cur_cnt < cur_cap) begin
            // append at the fill count
            pass_wr_idx = trsa_pkg::idx_t'(cur_cnt);
            if (is_tex) begin
              tex_we      = 1'b1;
              tex_pass_we = 1'b1;
              tex_vld_nxt[cur_cnt[trsa_pkg::TEX_AW-1:0]] = 1'b1;
              tex_cnt_nxt = tex_cnt_r + trsa_pkg::cnt_t'(1);
            end else begin
              buf_we      = 1'b1;
              buf_pass_we = 1'b1;
              buf_vld_nxt[cur_cnt[trsa_pkg::BUF_AW-1:0]] = 1'b1;
              buf_cnt_nxt = buf_cnt_r + trsa_pkg::cnt_t'(1);
            end
            res_nxt.slot_number = trsa_pkg::slot_num_t'(cur_cnt);
            res_nxt.fresh_slot  = 1'b1;
          end else begin
            res_nxt.pool_full = 1'b1;
          end
          state_nxt = ST_DONE;
        end else begin
          idx_nxt   = idx_r + trsa_pkg::idx_t'(1);
          scan_addr = idx_r + trsa_pkg::idx_t'(1);
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tex_cnt_r   <= '0;
      buf_cnt_r   <= '0;
      tex_vld_r   <= '0;
      buf_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tex_cnt_r   <= tex_cnt_nxt;
      buf_cnt_r   <= buf_cnt_nxt;
      tex_vld_r   <= tex_vld_nxt;
      buf_vld_r   <= buf_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    if (tex_pass_we) begin
      tex_pass_r[pass_wr_idx[trsa_pkg::TEX_AW-1:0]] <= last_pass;
    end
    if (buf_pass_we) begin
      buf_pass_r[pass_wr_idx[trsa_pkg::BUF_AW-1:0]] <= last_pass;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/core/trsa_checker.sv */
// Port-level checks for the transient resource slot allocator, bound to the top level.
// Depends on trsa_pkg and transient_resource_slot_allocator.
`default_nettype none

module trsa_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire trsa_pkg::rsp_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // append and full are exclusive
  a_fresh_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.fresh_slot && out_data.pool_full))
    else $error("fresh slot and pool full together");

  // a full pool reports slot zero
  a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pool_full |-> out_data.slot_number == '0)
    else $error("pool full with a nonzero slot");

endmodule

bind transient_resource_slot_allocator trsa_checker u_trsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for transient_resource_slot_allocator: directed table, then random
// sequences (frames, bursts, drops, spare codes, noise) under four idle/stall mixes. Depends on trsa_pkg and the RTL.

module testbench;

  // Operation codes the block leaves unused
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  localparam int TEX_POOL     = 0;
  localparam int BUF_POOL     = 1;
  localparam int POOL_DEPTH   = (trsa_pkg::TEX_SLOTS > trsa_pkg::BUF_SLOTS) ?
                                trsa_pkg::TEX_SLOTS : trsa_pkg::BUF_SLOTS;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int NUM_DIR      = 22;
  localparam int FLOOD_LEN    = 72;

  typedef logic signed [trsa_pkg::PASS_W:0] pass_mark_t;

  typedef struct {
    trsa_pkg::req_t item;
    bit             typed;
    trsa_pkg::rsp_t want;
  } dir_row_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  trsa_pkg::req_t in_data;
  logic           out_valid;
  logic           out_stall;
  trsa_pkg::rsp_t out_data;

  transient_resource_slot_allocator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Slot model: descriptors, last-use marks (-1 = free) and fill counts per pool
  trsa_pkg::tex_desc_t tex_desc_m[trsa_pkg::TEX_SLOTS];
  trsa_pkg::buf_desc_t buf_desc_m[trsa_pkg::BUF_SLOTS];
  pass_mark_t          busy_until[2][POOL_DEPTH];
  int                  pool_fill[2];

  trsa_pkg::rsp_t      pending_rsps[$];
  trsa_pkg::req_t      stim_q[$];
  dir_row_t            dir_rows[NUM_DIR];
  trsa_pkg::tex_desc_t tex_palette[4];
  trsa_pkg::buf_desc_t buf_palette[4];
  int        frame_pass;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        sender_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        idle_mix[4]  = '{0, 59, 0, 33};
  int        stall_mix[4] = '{0, 0, 59, 33};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void free_pool(int p);
    for (int i = 0; i < POOL_DEPTH; i++) busy_until[p][i] = pass_mark_t'(-1);
  endfunction

  function automatic void stim_add(trsa_pkg::req_t r);
    stim_q.insert(stim_q.size(), r);
  endfunction

  function automatic void expect_add(trsa_pkg::rsp_t s);
    pending_rsps.insert(pending_rsps.size(), s);
  endfunction

  function automatic pass_mark_t sat_pass(logic [7:0] v);
    int pv;
    pv = v;
    if (pv > trsa_pkg::MAX_PASSES - 1) pv = trsa_pkg::MAX_PASSES - 1;
    return pass_mark_t'(pv);
  endfunction

  function automatic bit slot_fits(int p, int i, trsa_pkg::req_t r);
    if (p == TEX_POOL) begin
      return tex_desc_m[i].fmt == r.pixel_format && tex_desc_m[i].w == r.tex_width &&
             tex_desc_m[i].h == r.tex_height && tex_desc_m[i].mips == r.mip_count &&
             (tex_desc_m[i].usage & r.usage_mask) == r.usage_mask;
    end
    return buf_desc_m[i].bytes >= r.buffer_bytes && buf_desc_m[i].vis == r.host_visible &&
           (buf_desc_m[i].usage & r.usage_mask) == r.usage_mask;
  endfunction

  // First-fit slot assignment; updates the model state
  function automatic trsa_pkg::rsp_t allocate_slot(trsa_pkg::req_t r);
    trsa_pkg::rsp_t res;
    int             p;
    int             cap;
    pass_mark_t     first_pass;
    pass_mark_t     last_pass;
    bit             hit;
    res = '0;
    hit = 1'b0;
    first_pass = sat_pass(r.first_use);
    last_pass = sat_pass(r.last_use);
    case (r.operation)
      trsa_pkg::OP_BEGIN_FRAME: begin
        free_pool(TEX_POOL);
        free_pool(BUF_POOL);
      end
      trsa_pkg::OP_DROP_TEX: begin
        pool_fill[TEX_POOL] = 0;
        free_pool(TEX_POOL);
      end
      trsa_pkg::OP_DROP_BUF: begin
        pool_fill[BUF_POOL] = 0;
        free_pool(BUF_POOL);
      end
      trsa_pkg::OP_TEX_REQ, trsa_pkg::OP_BUF_REQ: begin
        p = (r.operation == trsa_pkg::OP_TEX_REQ) ? TEX_POOL : BUF_POOL;
        cap = (p == TEX_POOL) ? trsa_pkg::TEX_SLOTS : trsa_pkg::BUF_SLOTS;
        for (int i = 0; i < pool_fill[p] && !hit; i++) begin
          if (slot_fits(p, i, r) && busy_until[p][i] < first_pass) begin
            busy_until[p][i] = last_pass;
            res.slot_number = trsa_pkg::slot_num_t'(i);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (pool_fill[p] < cap) begin
            if (p == TEX_POOL) begin
              tex_desc_m[pool_fill[p]] = '{r.pixel_format, r.tex_width, r.tex_height,
                                           r.mip_count, r.usage_mask};
            end else begin
              buf_desc_m[pool_fill[p]] = '{r.buffer_bytes, r.host_visible, r.usage_mask};
            end
            busy_until[p][pool_fill[p]] = last_pass;
            res.slot_number = trsa_pkg::slot_num_t'(pool_fill[p]);
            res.fresh_slot = 1'b1;
            pool_fill[p]++;
          end else begin
            res.pool_full = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic trsa_pkg::req_t mk_tex(input logic [4:0] fmt, input logic [14:0] w,
                                            input logic [14:0] h, input logic [3:0] mips,
                                            input logic [7:0] usage, input logic [7:0] first,
                                            input logic [7:0] last);
    trsa_pkg::req_t r;
    r = '0;
    r.operation = trsa_pkg::OP_TEX_REQ;
    r.pixel_format = fmt;
    r.tex_width = w;
    r.tex_height = h;
    r.mip_count = mips;
    r.usage_mask = usage;
    r.first_use = first;
    r.last_use = last;
    return r;
  endfunction

  function automatic trsa_pkg::req_t mk_buf(input logic [31:0] bytes, input logic vis,
                                            input logic [7:0] usage, input logic [7:0] first,
                                            input logic [7:0] last);
    trsa_pkg::req_t r;
    r = '0;
    r.operation = trsa_pkg::OP_BUF_REQ;
    r.buffer_bytes = bytes;
    r.host_visible = vis;
    r.usage_mask = usage;
    r.first_use = first;
    r.last_use = last;
    return r;
  endfunction

  function automatic trsa_pkg::req_t mk_op(input logic [2:0] op);
    trsa_pkg::req_t r;
    r = '0;
    r.operation = op;
    return r;
  endfunction

  function automatic trsa_pkg::rsp_t mk_rsp(input logic [4:0] slot, input logic fresh,
                                            input logic full);
    trsa_pkg::rsp_t s;
    s.slot_number = slot;
    s.fresh_slot = fresh;
    s.pool_full = full;
    return s;
  endfunction

  // Every field, operation included, fully random
  function automatic trsa_pkg::req_t noise_item();
    logic [127:0]   bits;
    trsa_pkg::req_t r;
    bits = {$urandom, $urandom, $urandom, $urandom};
    r = bits[$bits(trsa_pkg::req_t)-1:0];
    return r;
  endfunction

  // Well-formed request: mostly palette descriptors, first use rising within the frame
  function automatic trsa_pkg::req_t framed_request(int p);
    trsa_pkg::req_t r;
    int             k;
    int             fu;
    int             lu;
    r = noise_item();
    k = $urandom_range(3, 0);
    if (p == TEX_POOL) begin
      r.operation = trsa_pkg::OP_TEX_REQ;
      if ($urandom_range(9, 0) != 0) begin
        r.pixel_format = tex_palette[k].fmt;
        r.tex_width = tex_palette[k].w;
        r.tex_height = tex_palette[k].h;
        r.mip_count = tex_palette[k].mips;
        r.usage_mask = tex_palette[k].usage & 8'($urandom);
      end else begin
        r.tex_width = 15'($urandom_range(16384, 1));
        r.tex_height = 15'($urandom_range(16384, 1));
        r.mip_count = 4'($urandom_range(15, 1));
      end
    end else begin
      r.operation = trsa_pkg::OP_BUF_REQ;
      if ($urandom_range(9, 0) != 0) begin
        r.buffer_bytes = buf_palette[k].bytes >> $urandom_range(2, 0);
        r.host_visible = buf_palette[k].vis;
        r.usage_mask = buf_palette[k].usage & 8'($urandom);
      end
    end
    fu = frame_pass + $urandom_range(3, 0);
    if (fu > 255) fu = 255;
    frame_pass = fu;
    lu = fu + $urandom_range(24, 0);
    if (lu > 255) lu = 255;
    r.first_use = 8'(fu);
    r.last_use = 8'(lu);
    return r;
  endfunction

  // Queue up one random sequence of transfers
  task automatic fill_sequence();
    int             pick;
    int             p;
    trsa_pkg::req_t r;
    pick = $urandom_range(99, 0);
    p = $urandom_range(1, 0);
    if (pick < 68) begin
      r = noise_item();
      r.operation = trsa_pkg::OP_BEGIN_FRAME;
      stim_add(r);
      frame_pass = 0;
      repeat ($urandom_range(12, 1)) stim_add(framed_request($urandom_range(1, 0)));
    end else if (pick < 70) begin
      // long burst at one pool: reuses compatible free slots, then appends until full
      repeat (FLOOD_LEN) begin
        r = framed_request(p);
        r.first_use = 8'd0;
        r.last_use = 8'hFF;
        stim_add(r);
      end
    end else if (pick < 76) begin
      r = noise_item();
      r.operation = (p == TEX_POOL) ? trsa_pkg::OP_DROP_TEX : trsa_pkg::OP_DROP_BUF;
      stim_add(r);
    end else if (pick < 80) begin
      r = noise_item();
      r.operation = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      stim_add(r);
    end else if (pick < 90) begin
      repeat ($urandom_range(3, 1)) stim_add(noise_item());
    end else begin
      repeat ($urandom_range(8, 1)) stim_add(framed_request($urandom_range(1, 0)));
    end
  endtask

  // Drive one transfer; record its expected result once it is taken
  task automatic push_item(input trsa_pkg::req_t r, input bit typed,
                           input trsa_pkg::rsp_t want);
    trsa_pkg::rsp_t got;
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = allocate_slot(r);
    expect_add(typed ? want : got);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  always @(posedge clk) begin
    trsa_pkg::rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: slot %0d fresh %0b full %0b", $time,
                 out_data.slot_number, out_data.fresh_slot, out_data.pool_full);
      end else begin
        want = pending_rsps.pop_front();
        if (out_data.slot_number !== want.slot_number ||
            out_data.fresh_slot !== want.fresh_slot ||
            out_data.pool_full !== want.pool_full) begin
          mismatches++;
          $display({"%0t: mismatch: expected slot %0d fresh %0b full %0b, ",
                    "got slot %0d fresh %0b full %0b"},
                   $time, want.slot_number, want.fresh_slot, want.pool_full,
                   out_data.slot_number, out_data.fresh_slot, out_data.pool_full);
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int sent;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    sent = 0;
    frame_pass = 0;
    pool_fill[TEX_POOL] = 0;
    pool_fill[BUF_POOL] = 0;
    free_pool(TEX_POOL);
    free_pool(BUF_POOL);
    for (int k = 0; k < 4; k++) begin
      tex_palette[k] = '{5'($urandom), 15'($urandom_range(16384, 1)),
                         15'($urandom_range(16384, 1)), 4'($urandom_range(15, 1)),
                         8'($urandom)};
      buf_palette[k] = '{$urandom, 1'($urandom), 8'($urandom)};
    end

    // Directed table: textures and buffers at the extremes, then spare and drop codes
    dir_rows = '{
      '{mk_op(trsa_pkg::OP_BEGIN_FRAME), 1'b1, mk_rsp(5'd0, 1'b0, 1'b0)},
      '{mk_op(OP_SPARE_LO), 1'b1, mk_rsp(5'd0, 1'b0, 1'b0)},
      '{mk_tex(5'd31, 15'd16384, 15'd16384, 4'd15, 8'hFF, 8'd0, 8'd3), 1'b1,
        mk_rsp(5'd0, 1'b1, 1'b0)},
      // slot 0 still busy at pass 2
      '{mk_tex(5'd31, 15'd16384, 15'd16384, 4'd15, 8'hFF, 8'd2, 8'd9), 1'b1,
        mk_rsp(5'd1, 1'b1, 1'b0)},
      // usage subset reuses slot 0
      '{mk_tex(5'd31, 15'd16384, 15'd16384, 4'd15, 8'h81, 8'd4, 8'd255), 1'b1,
        mk_rsp(5'd0, 1'b0, 1'b0)},
      // last use before first use
      '{mk_tex(5'd0, 15'd1, 15'd1, 4'd1, 8'h00, 8'd200, 8'd10), 1'b1,
        mk_rsp(5'd2, 1'b1, 1'b0)},
      '{mk_tex(5'd0, 15'd1, 15'd1, 4'd1, 8'h00, 8'd11, 8'd20), 1'b0, '0},
      '{mk_tex(5'd31, 15'd16384, 15'd16384, 4'd14, 8'hFF, 8'd255, 8'd255), 1'b0, '0},
      '{mk_buf(32'hFFFF_FFFF, 1'b1, 8'hFF, 8'd0, 8'd0), 1'b1, mk_rsp(5'd0, 1'b1, 1'b0)},
      '{mk_buf(32'd0, 1'b1, 8'h00, 8'd1, 8'd255), 1'b1, mk_rsp(5'd0, 1'b0, 1'b0)},
      '{mk_buf(32'd100, 1'b0, 8'h01, 8'd255, 8'd255), 1'b0, '0},
      '{mk_buf(32'd101, 1'b0, 8'h01, 8'd255, 8'd255), 1'b0, '0},
      '{mk_op(trsa_pkg::OP_BEGIN_FRAME), 1'b1, mk_rsp(5'd0, 1'b0, 1'b0)},
      '{mk_buf(32'd50, 1'b0, 8'h01, 8'd0, 8'd7), 1'b0, '0},
      '{mk_tex(5'd31, 15'd16384, 15'd16384, 4'd15, 8'h0F, 8'd0, 8'd0), 1'b0, '0},
      '{mk_op(OP_SPARE_MID), 1'b1, mk_rsp(5'd0, 1'b0, 1'b0)},
      '{mk_op(OP_SPARE_HI), 1'b1, mk_rsp(5'd0, 1'b0, 1'b0)},
      '{mk_op(trsa_pkg::OP_DROP_TEX), 1'b1, mk_rsp(5'd0, 1'b0, 1'b0)},
      '{mk_tex(5'd31, 15'd16384, 15'd16384, 4'd15, 8'hFF, 8'd0, 8'd1), 1'b1,
        mk_rsp(5'd0, 1'b1, 1'b0)},
      '{mk_op(trsa_pkg::OP_DROP_BUF), 1'b1, mk_rsp(5'd0, 1'b0, 1'b0)},
      '{mk_buf(32'd0, 1'b0, 8'h00, 8'd0, 8'd0), 1'b1, mk_rsp(5'd0, 1'b1, 1'b0)},
      // extreme sizes: width all ones, height zero
      '{mk_tex(5'd0, 15'h7FFF, 15'd0, 4'd0, 8'h00, 8'd255, 8'd0), 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < NUM_DIR; k++) begin
      push_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    end

    // Random part in four mixes of sender idling and receiver stalling
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      while (sent < (ph + 1) * RANDOM_ITEMS / 4) begin
        if (stim_q.size() == 0) fill_sequence();
        push_item(stim_q.pop_front(), 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* transient_resource_slot_allocator.f */
rtl/core/trsa_pkg.sv
rtl/core/trsa_ram.sv
rtl/core/transient_resource_slot_allocator.sv
rtl/core/trsa_checker.sv
bench/testbench.sv
